// ----- src/circle_contact_backoff_unit_defines.svh -----
// Assertion macros used by the queue (ccb_fifo.sv).
`ifndef CIRCLE_CONTACT_BACKOFF_UNIT_DEFINES_SVH
`define CIRCLE_CONTACT_BACKOFF_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define CCB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define CCB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ccb_pkg.sv -----
`default_nettype none

package ccb_pkg;

  // Coordinate format
  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int RADIUS_W = CW - 1;

  // Internal widths of the contact solve
  localparam int PW   = CW + 1;          // target minus mover
  localparam int AW   = 2 * CW;          // |v|^2, unsigned
  localparam int BW   = 2 * CW + 2;      // p.v, signed
  localparam int CCW  = 2 * CW + 3;      // |p|^2 - r^2, signed
  localparam int DW   = 4 * CW + 3;      // discriminant, signed
  localparam int RADW = DW - 1;          // radicand, unsigned
  localparam int SQW  = RADW / 2;        // root width
  localparam int SRW  = SQW + 3;         // root remainder width
  localparam int NW   = SQW + 2;         // root minus p.v, signed

  // Wide multiplier built from narrow partial products
  localparam int MDIG    = 23;
  localparam int MND     = (2 * CW + 2 + MDIG - 1) / MDIG;
  localparam int MW      = MDIG * MND;
  localparam int MPW     = 2 * MW;
  localparam int MUL_LAT = MND * MND;

  // Divider and clamp
  localparam int QW  = CW + 2;           // quotient bits kept
  localparam int PDW = AW + QW;          // dividend width
  localparam int RW  = QW + 2;           // clamp arithmetic width

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Stream widths
  localparam int IN_TDATA_W  = ((8 * CW - 2 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * CW;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CONTACT = 2'd1,
    ST_ZERO_VEL   = 2'd2,
    ST_SAT        = 2'd3
  } status_e;

  // Classified item passed from front to back
  typedef struct packed {
    logic signed [CW-1:0]  mover_x;
    logic signed [CW-1:0]  mover_y;
    logic signed [CW-1:0]  vel_x;
    logic signed [CW-1:0]  vel_y;
    logic [AW-1:0]         a;
    logic signed [BW-1:0]  b;
    logic signed [CCW-1:0] c;
  } job_t;

endpackage

`default_nettype wire

// ----- src/ccb_mul.sv -----
`default_nettype none

module ccb_mul (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ccb_pkg::MW-1:0]    a_i,
  input  logic [ccb_pkg::MW-1:0]    b_i,
  output logic [ccb_pkg::MPW-1:0]   p_o
);
  import ccb_pkg::*;

  logic [MW-1:0]  a_q   [MUL_LAT];
  logic [MW-1:0]  b_q   [MUL_LAT];
  logic [MPW-1:0] acc_q [MUL_LAT];

  // One digit pair per stage, accumulated into the running sum
  for (genvar k = 0; k < MUL_LAT; k++) begin : g_stage
    localparam int DI = k / MND;
    localparam int DJ = k % MND;
    logic [MW-1:0]     a_in;
    logic [MW-1:0]     b_in;
    logic [MPW-1:0]    acc_in;
    logic [2*MDIG-1:0] pr;

    if (k == 0) begin : g_first
      assign a_in   = a_i;
      assign b_in   = b_i;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign pr = (2*MDIG)'(a_in[DI*MDIG +: MDIG]) * (2*MDIG)'(b_in[DJ*MDIG +: MDIG]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_in;
        b_q[k]   <= b_in;
        acc_q[k] <= acc_in + (MPW'(pr) << ((DI + DJ) * MDIG));
      end
    end
  end

  assign p_o = acc_q[MUL_LAT-1];

endmodule

`default_nettype wire

// ----- src/ccb_sqrt.sv -----
`default_nettype none

module ccb_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ccb_pkg::RADW-1:0]  rad_i,
  output logic [ccb_pkg::SQW-1:0]   root_o
);
  import ccb_pkg::*;

  logic [RADW-1:0] rad_q  [SQW];
  logic [SRW-1:0]  rem_q  [SQW];
  logic [SQW-1:0]  root_q [SQW];

  // One root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < SQW; k++) begin : g_stage
    logic [RADW-1:0] rad_in;
    logic [SRW-1:0]  rem_in;
    logic [SQW-1:0]  root_in;
    logic [SRW-1:0]  remx;
    logic [SRW-1:0]  trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign remx  = {rem_in[SRW-3:0], rad_in[RADW-1 -: 2]};
    assign trial = SRW'({root_in, 2'b01});
    assign ge    = (remx >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (remx - trial) : remx;
        root_q[k] <= {root_in[SQW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SQW-1];

endmodule

`default_nettype wire

// ----- src/ccb_div.sv -----
`default_nettype none

module ccb_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ccb_pkg::PDW-1:0]  p_i,
  input  logic [ccb_pkg::AW-1:0]   a_i,
  output logic [ccb_pkg::QW-1:0]   q_o,
  output logic                     big_o
);
  import ccb_pkg::*;

  logic [QW-1:0] num_q [QW];
  logic [AW-1:0] rem_q [QW];
  logic [AW-1:0] a_q   [QW];
  logic [QW-1:0] q_q   [QW];
  logic          big_q [QW];

  // Restoring division, one quotient bit per stage; the top part of the
  // dividend at or above the divisor means the quotient does not fit
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] num_in;
    logic [AW-1:0] rem_in;
    logic [AW-1:0] a_in;
    logic [QW-1:0] q_in;
    logic          big_in;
    logic [AW:0]   remx;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_in = p_i[QW-1:0];
      assign rem_in = p_i[PDW-1:QW];
      assign a_in   = a_i;
      assign q_in   = '0;
      assign big_in = (p_i[PDW-1:QW] >= a_i);
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign a_in   = a_q[k-1];
      assign q_in   = q_q[k-1];
      assign big_in = big_q[k-1];
    end

    assign remx = {rem_in, num_in[QW-1]};
    assign ge   = (remx >= {1'b0, a_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in << 1;
        rem_q[k] <= ge ? AW'(remx - {1'b0, a_in}) : remx[AW-1:0];
        a_q[k]   <= a_in;
        q_q[k]   <= {q_in[QW-2:0], ge};
        big_q[k] <= big_in;
      end
    end
  end

  assign q_o   = q_q[QW-1];
  assign big_o = big_q[QW-1];

endmodule

`default_nettype wire

// ----- src/ccb_front.sv -----
`default_nettype none

module ccb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_func_i,
  input  logic [ccb_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            full_i,
  output logic                            push_o,
  output ccb_pkg::job_t                   job_o
);
  import ccb_pkg::*;

  localparam int OFF_MY = CW;
  localparam int OFF_MR = 2 * CW;
  localparam int OFF_OR = OFF_MR + RADIUS_W;
  localparam int OFF_TX = OFF_OR + RADIUS_W;
  localparam int OFF_TY = OFF_TX + CW;
  localparam int OFF_VX = OFF_TY + CW;
  localparam int OFF_VY = OFF_VX + CW;
  localparam logic [CW-1:0] WHOLE_MASK = {{(CW-FB){1'b1}}, {FB{1'b0}}};

  logic signed [CW-1:0] mx, my, tx, ty, vx, vy;
  logic [RADIUS_W-1:0]  mr, orad;
  logic [CW-1:0]        r_sum;
  logic                 fe;

  logic                   f1_valid_q;
  logic signed [CW-1:0]   f1_mx_q, f1_my_q, f1_vx_q, f1_vy_q;
  logic signed [PW-1:0]   f1_px_q, f1_py_q;
  logic [CW-1:0]          f1_r_q;

  logic                     f2_valid_q;
  logic signed [CW-1:0]     f2_mx_q, f2_my_q, f2_vx_q, f2_vy_q;
  logic signed [AW-1:0]     f2_vx2_q, f2_vy2_q;
  logic signed [PW+CW-1:0]  f2_pxvx_q, f2_pyvy_q;
  logic signed [2*PW-1:0]   f2_px2_q, f2_py2_q;
  logic [AW-1:0]            f2_r2_q;

  // Unpack the transaction
  assign mx   = $signed(in_data_i[0 +: CW]);
  assign my   = $signed(in_data_i[OFF_MY +: CW]);
  assign mr   = in_data_i[OFF_MR +: RADIUS_W];
  assign orad = in_data_i[OFF_OR +: RADIUS_W];
  assign tx   = $signed(in_data_i[OFF_TX +: CW]);
  assign ty   = $signed(in_data_i[OFF_TY +: CW]);
  assign vx   = $signed(in_data_i[OFF_VX +: CW]);
  assign vy   = $signed(in_data_i[OFF_VY +: CW]);

  assign r_sum = CW'(mr) + CW'(orad);

  // Advance both front stages unless the last one is blocked by a full queue
  assign fe         = !f2_valid_q || !full_i;
  assign in_ready_o = fe;
  assign push_o     = f2_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (fe) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  // Offsets and contact radius
  always_ff @(posedge clk_i) begin
    if (fe) begin
      f1_mx_q <= mx;
      f1_my_q <= my;
      f1_vx_q <= vx;
      f1_vy_q <= vy;
      f1_px_q <= PW'(tx) - PW'(mx);
      f1_py_q <= PW'(ty) - PW'(my);
      f1_r_q  <= in_func_i ? (r_sum & WHOLE_MASK) : CW'(mr);
    end
  end

  // Products of the quadratic's coefficients
  always_ff @(posedge clk_i) begin
    if (fe) begin
      f2_mx_q   <= f1_mx_q;
      f2_my_q   <= f1_my_q;
      f2_vx_q   <= f1_vx_q;
      f2_vy_q   <= f1_vy_q;
      f2_vx2_q  <= AW'(f1_vx_q) * AW'(f1_vx_q);
      f2_vy2_q  <= AW'(f1_vy_q) * AW'(f1_vy_q);
      f2_pxvx_q <= (PW+CW)'(f1_px_q) * (PW+CW)'(f1_vx_q);
      f2_pyvy_q <= (PW+CW)'(f1_py_q) * (PW+CW)'(f1_vy_q);
      f2_px2_q  <= (2*PW)'(f1_px_q) * (2*PW)'(f1_px_q);
      f2_py2_q  <= (2*PW)'(f1_py_q) * (2*PW)'(f1_py_q);
      f2_r2_q   <= AW'(f1_r_q) * AW'(f1_r_q);
    end
  end

  // Sum into A, B, C
  always_comb begin
    job_o.mover_x = f2_mx_q;
    job_o.mover_y = f2_my_q;
    job_o.vel_x   = f2_vx_q;
    job_o.vel_y   = f2_vy_q;
    job_o.a       = $unsigned(f2_vx2_q + f2_vy2_q);
    job_o.b       = BW'(f2_pxvx_q) + BW'(f2_pyvy_q);
    job_o.c       = CCW'(f2_px2_q) + CCW'(f2_py2_q) - $signed(CCW'(f2_r2_q));
  end

endmodule

`default_nettype wire

// ----- src/ccb_fifo.sv -----
`default_nettype none

`include "circle_contact_backoff_unit_defines.svh"

module ccb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccb_pkg::job_t  job_i,
  input  logic           pop_i,
  output ccb_pkg::job_t  job_o,
  output logic           empty_o,
  output logic           full_o
);
  import ccb_pkg::*;

  job_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]    count_q, count_d;

  assign job_o   = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Track fill level
  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  `CCB_ASSERT_IMP(a_no_underflow, pop_i, count_q != '0, "ccb_fifo: pop from empty queue")
  `CCB_ASSERT_IMP(a_no_overflow, push_i, count_q != (FIFO_AW+1)'(FIFO_DEPTH), "ccb_fifo: push on full")
  `CCB_ASSERT_NXT(a_cnt_inc, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "ccb_fifo: bad inc")
  `CCB_ASSERT_NXT(a_cnt_dec, pop_i && !push_i, count_q == $past(count_q) - 1'b1, "ccb_fifo: bad dec")

endmodule

`default_nettype wire

// ----- src/ccb_back.sv -----
`default_nettype none

module ccb_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ccb_pkg::job_t            job_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ccb_pkg::CW-1:0]   result_x_o,
  output logic [ccb_pkg::CW-1:0]   result_y_o,
  output ccb_pkg::status_e         status_o
);
  import ccb_pkg::*;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] mx, my, vx, vy;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
    logic                 c_neg;
  } s1_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] mx, my, vx, vy;
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
    logic                 zero;
    logic                 neg;
  } s2_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] mx, my, vx, vy;
    logic [AW-1:0]        a;
    logic                 zero;
    logic                 neg;
  } s3_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] mx, my;
    logic [AW-1:0]        a;
    logic                 zero;
    logic                 neg;
    logic                 sx, sy;
  } s4_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] mx, my;
    logic                 zero;
    logic                 neg;
    logic                 sx, sy;
  } s5_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } coord_res_t;

  // Subtract the signed quotient from the mover and clamp
  function automatic coord_res_t back_off(logic signed [CW-1:0] mv, logic [QW-1:0] q,
                                          logic big, logic sn);
    logic signed [RW-1:0] qs;
    logic signed [RW-1:0] res;
    coord_res_t           r;
    qs    = sn ? -$signed(RW'(q)) : $signed(RW'(q));
    res   = RW'(mv) - qs;
    r.sat = 1'b1;
    priority if (big) begin
      r.val = sn ? CMAX : CMIN;
    end else if (res > RW'(CMAX)) begin
      r.val = CMAX;
    end else if (res < RW'(CMIN)) begin
      r.val = CMIN;
    end else begin
      r.sat = 1'b0;
      r.val = res[CW-1:0];
    end
    return r;
  endfunction

  logic adv;

  s1_t s1_d;
  s1_t s1_q [MUL_LAT];
  logic [BW-1:0]  b_abs;
  logic [CCW-1:0] c_abs;
  logic [MPW-1:0] bb_p, ac_p;

  logic signed [DW-1:0] bb_s, ac_s, d_d, d_q;
  s2_t s2_d, s2h_q;
  s2_t s2_q [SQW];
  logic [SQW-1:0] root;

  logic signed [NW-1:0] n_q;
  s3_t s3h_q;
  logic [CW-1:0] vx_abs, vy_abs;
  logic [NW-1:0] n_abs;
  logic [MPW-1:0] px_p, py_p;
  s4_t s4_d;
  s4_t s4_q [MUL_LAT];

  logic [QW-1:0] qx, qy;
  logic          bigx, bigy;
  s5_t s5_q [QW];
  s5_t s5t;
  coord_res_t rx, ry;

  logic          out_valid_q;
  logic [CW-1:0] res_x_q, res_y_q;
  status_e       status_q;

  // Whole pipeline moves when the output register is free or being taken
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage entry: magnitudes for B^2 and A*C
  assign b_abs = job_i.b[BW-1] ? $unsigned(-job_i.b) : $unsigned(job_i.b);
  assign c_abs = job_i.c[CCW-1] ? $unsigned(-job_i.c) : $unsigned(job_i.c);

  always_comb begin
    s1_d.valid = !empty_i;
    s1_d.mx    = job_i.mover_x;
    s1_d.my    = job_i.mover_y;
    s1_d.vx    = job_i.vel_x;
    s1_d.vy    = job_i.vel_y;
    s1_d.a     = job_i.a;
    s1_d.b     = job_i.b;
    s1_d.c_neg = job_i.c[CCW-1];
  end

  ccb_mul u_mul_bb (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (MW'(b_abs)),
    .b_i   (MW'(b_abs)),
    .p_o   (bb_p)
  );

  ccb_mul u_mul_ac (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (MW'(job_i.a)),
    .b_i   (MW'(c_abs)),
    .p_o   (ac_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '{default: '0};
    end else if (adv) begin
      s1_q[0] <= s1_d;
      for (int i = 1; i < MUL_LAT; i++) begin
        s1_q[i] <= s1_q[i-1];
      end
    end
  end

  // Discriminant
  assign bb_s = $signed(bb_p[DW-1:0]);
  assign ac_s = $signed(ac_p[DW-1:0]);
  assign d_d  = s1_q[MUL_LAT-1].c_neg ? (bb_s + ac_s) : (bb_s - ac_s);

  always_comb begin
    s2_d.valid = s1_q[MUL_LAT-1].valid;
    s2_d.mx    = s1_q[MUL_LAT-1].mx;
    s2_d.my    = s1_q[MUL_LAT-1].my;
    s2_d.vx    = s1_q[MUL_LAT-1].vx;
    s2_d.vy    = s1_q[MUL_LAT-1].vy;
    s2_d.a     = s1_q[MUL_LAT-1].a;
    s2_d.b     = s1_q[MUL_LAT-1].b;
    s2_d.zero  = (s1_q[MUL_LAT-1].a == '0);
    s2_d.neg   = d_d[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2h_q <= '0;
    end else if (adv) begin
      s2h_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q <= d_d;
    end
  end

  // Integer square root of the discriminant
  ccb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (d_q[RADW-1:0]),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '{default: '0};
    end else if (adv) begin
      s2_q[0] <= s2h_q;
      for (int i = 1; i < SQW; i++) begin
        s2_q[i] <= s2_q[i-1];
      end
    end
  end

  // Numerator of t: root minus p.v
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3h_q <= '0;
    end else if (adv) begin
      s3h_q.valid <= s2_q[SQW-1].valid;
      s3h_q.mx    <= s2_q[SQW-1].mx;
      s3h_q.my    <= s2_q[SQW-1].my;
      s3h_q.vx    <= s2_q[SQW-1].vx;
      s3h_q.vy    <= s2_q[SQW-1].vy;
      s3h_q.a     <= s2_q[SQW-1].a;
      s3h_q.zero  <= s2_q[SQW-1].zero;
      s3h_q.neg   <= s2_q[SQW-1].neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q <= $signed(NW'(root)) - NW'(s2_q[SQW-1].b);
    end
  end

  // Velocity times numerator, by magnitude
  assign vx_abs = s3h_q.vx[CW-1] ? $unsigned(-s3h_q.vx) : $unsigned(s3h_q.vx);
  assign vy_abs = s3h_q.vy[CW-1] ? $unsigned(-s3h_q.vy) : $unsigned(s3h_q.vy);
  assign n_abs  = n_q[NW-1] ? $unsigned(-n_q) : $unsigned(n_q);

  ccb_mul u_mul_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (MW'(vx_abs)),
    .b_i   (MW'(n_abs)),
    .p_o   (px_p)
  );

  ccb_mul u_mul_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (MW'(vy_abs)),
    .b_i   (MW'(n_abs)),
    .p_o   (py_p)
  );

  always_comb begin
    s4_d.valid = s3h_q.valid;
    s4_d.mx    = s3h_q.mx;
    s4_d.my    = s3h_q.my;
    s4_d.a     = s3h_q.a;
    s4_d.zero  = s3h_q.zero;
    s4_d.neg   = s3h_q.neg;
    s4_d.sx    = s3h_q.vx[CW-1] ^ n_q[NW-1];
    s4_d.sy    = s3h_q.vy[CW-1] ^ n_q[NW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '{default: '0};
    end else if (adv) begin
      s4_q[0] <= s4_d;
      for (int i = 1; i < MUL_LAT; i++) begin
        s4_q[i] <= s4_q[i-1];
      end
    end
  end

  // Divide by |v|^2
  ccb_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .p_i   (px_p[PDW-1:0]),
    .a_i   (s4_q[MUL_LAT-1].a),
    .q_o   (qx),
    .big_o (bigx)
  );

  ccb_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .p_i   (py_p[PDW-1:0]),
    .a_i   (s4_q[MUL_LAT-1].a),
    .q_o   (qy),
    .big_o (bigy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '{default: '0};
    end else if (adv) begin
      s5_q[0].valid <= s4_q[MUL_LAT-1].valid;
      s5_q[0].mx    <= s4_q[MUL_LAT-1].mx;
      s5_q[0].my    <= s4_q[MUL_LAT-1].my;
      s5_q[0].zero  <= s4_q[MUL_LAT-1].zero;
      s5_q[0].neg   <= s4_q[MUL_LAT-1].neg;
      s5_q[0].sx    <= s4_q[MUL_LAT-1].sx;
      s5_q[0].sy    <= s4_q[MUL_LAT-1].sy;
      for (int i = 1; i < QW; i++) begin
        s5_q[i] <= s5_q[i-1];
      end
    end
  end

  // Back off, clamp and pick the status
  assign s5t = s5_q[QW-1];
  assign rx  = back_off(s5t.mx, qx, bigx, s5t.sx);
  assign ry  = back_off(s5t.my, qy, bigy, s5t.sy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s5t.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      priority if (s5t.zero) begin
        res_x_q  <= s5t.mx;
        res_y_q  <= s5t.my;
        status_q <= ST_ZERO_VEL;
      end else if (s5t.neg) begin
        res_x_q  <= s5t.mx;
        res_y_q  <= s5t.my;
        status_q <= ST_NO_CONTACT;
      end else begin
        res_x_q  <= rx.val;
        res_y_q  <= ry.val;
        status_q <= (rx.sat || ry.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_x_o  = res_x_q;
  assign result_y_o  = res_y_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ----- src/circle_contact_backoff_unit.sv -----
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tdata: mover, radii, target, velocity; tuser: func
// m_axis   out  m_axis_tvalid/tready   tdata: result_x, result_y; tuser: status
//
// One transaction accepted per cycle unless a full queue holds the front; an input
// passes two front stages, one queue slot, then 120 back stages (2 x 9 multiplier
// stages, 65 root stages, 34 divider stages, 3 more).
// The root and divider pipelines, one bit per stage, set the latency.
// rst_ni clears all valid state; the queue is empty after reset.
// A stalled output holds the back pipeline; the 4-entry queue lets the
// front keep taking input until it fills.
`default_nettype none

module circle_contact_backoff_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // mover_x, mover_y, mover_radius, other_radius, target_x, target_y, vel_x, vel_y
  input  logic [ccb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // result_x, result_y
  output logic [ccb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                       m_axis_tuser
);
  import ccb_pkg::*;

  job_t          push_job, head_job;
  logic          push, pop, empty, full;
  logic [CW-1:0] res_x, res_y;
  status_e       status;

  ccb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  ccb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  ccb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_x_o  (res_x),
    .result_y_o  (res_y),
    .status_o    (status)
  );

  assign m_axis_tdata = {res_y, res_x};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ----- bench/tb_circle_contact_backoff_unit.sv -----
`default_nettype none

module tb_circle_contact_backoff_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ccb_pkg::*;

  localparam int N_RANDOM    = 630;
  localparam int QUIET_TAIL  = 80;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 140;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic               func;
    logic signed [31:0] mover_x;
    logic signed [31:0] mover_y;
    logic [30:0]        mover_radius;
    logic [30:0]        other_radius;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } contact_req_t;

  typedef struct {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    status_e            status;
  } contact_res_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  contact_req_t pending_reqs[$];
  contact_res_t expected_contacts[$];
  contact_req_t cur_req;
  int           total_reqs;
  int           sent_cnt;
  int           recv_cnt;
  int           err_cnt;
  int           cycle_cnt;
  int           send_gap;
  int           recv_stall;
  int           hold_cnt;
  bit           long_hold_done;
  int           status_seen[4];
  logic         quiet;

  circle_contact_backoff_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  assign quiet = (sent_cnt >= total_reqs - QUIET_TAIL);

  // Clamp one backed-off coordinate to the signed 32-bit range
  function automatic logic signed [31:0] clamp_coord(wide_t val, ref bit sat);
    wide_t hi;
    wide_t lo;
    hi = 32'sh7FFF_FFFF;
    lo = 32'sh8000_0000;
    if (val > hi) begin
      sat = 1'b1;
      return hi[31:0];
    end
    if (val < lo) begin
      sat = 1'b1;
      return lo[31:0];
    end
    return val[31:0];
  endfunction

  // Solve for the larger root and back the mover off along its velocity
  function automatic contact_res_t solve_contact(contact_req_t rq);
    contact_res_t res;
    wide_t        px, py, vx, vy, rad, a, b, c, d, root, num;
    logic [255:0] rad_u, disc, cand, acc;
    logic [31:0]  rsum;
    bit           sat;
    px  = rq.target_x - rq.mover_x;
    py  = rq.target_y - rq.mover_y;
    vx  = rq.vel_x;
    vy  = rq.vel_y;
    rsum = {1'b0, rq.mover_radius};
    if (rq.func) begin
      rsum = {1'b0, rq.mover_radius} + {1'b0, rq.other_radius};
      rsum[15:0] = '0;
    end
    rad_u = {224'b0, rsum};
    rad   = rad_u;
    res.result_x = rq.mover_x;
    res.result_y = rq.mover_y;
    a = vx * vx + vy * vy;
    if (a == 0) begin
      res.status = ST_ZERO_VEL;
      return res;
    end
    b = px * vx + py * vy;
    c = px * px + py * py - rad * rad;
    d = b * b - a * c;
    if (d < 0) begin
      res.status = ST_NO_CONTACT;
      return res;
    end
    // Bitwise integer square root
    disc = d;
    acc  = '0;
    for (int k = 127; k >= 0; k--) begin
      cand = acc | (256'd1 << k);
      if (cand * cand <= disc) acc = cand;
    end
    root = acc;
    num  = root - b;
    sat  = 1'b0;
    res.result_x = clamp_coord(wide_t'(rq.mover_x) - (vx * num) / a, sat);
    res.result_y = clamp_coord(wide_t'(rq.mover_y) - (vy * num) / a, sat);
    res.status   = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  function automatic contact_req_t mk_req(logic fn, int mx, int my, int mr, int orad,
                                          int tx, int ty, int vx, int vy);
    contact_req_t rq;
    rq.func         = fn;
    rq.mover_x      = mx;
    rq.mover_y      = my;
    rq.mover_radius = mr[30:0];
    rq.other_radius = orad[30:0];
    rq.target_x     = tx;
    rq.target_y     = ty;
    rq.vel_x        = vx;
    rq.vel_y        = vy;
    return rq;
  endfunction

  function automatic int small_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly well-formed geometry with random content, some raw noise
  function automatic contact_req_t rand_req();
    contact_req_t rq;
    int           kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      rq = mk_req($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    end else begin
      rq = mk_req($urandom_range(0, 1), small_signed(1 << 22), small_signed(1 << 22),
                  $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 21), 0, 0,
                  small_signed(1 << 18), small_signed(1 << 18));
      rq.target_x = rq.mover_x + small_signed(1 << 21);
      rq.target_y = rq.mover_y + small_signed(1 << 21);
      if (kind == 9) begin
        rq.vel_x = '0;
        rq.vel_y = '0;
      end
    end
    return rq;
  endfunction

  // Driver: offer pending requests, record expectations on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_contacts.push_back(solve_contact(cur_req));
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata <= {2'b00, cur_req.vel_y, cur_req.vel_x, cur_req.target_y,
                           cur_req.target_x, cur_req.other_radius, cur_req.mover_radius,
                           cur_req.mover_y, cur_req.mover_x};
          s_axis_tuser  <= cur_req.func;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Receiver readiness: random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
      hold_cnt   = 0;
      long_hold_done = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && recv_cnt >= 60) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      recv_stall = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    contact_res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      recv_cnt++;
      if (expected_contacts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        err_cnt++;
      end else begin
        exp_res = expected_contacts.pop_front();
        status_seen[exp_res.status]++;
        if (m_axis_tdata[31:0] !== exp_res.result_x) begin
          $display("%0t: result_x expected %h actual %h", $time, exp_res.result_x,
                   m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[63:32] !== exp_res.result_y) begin
          $display("%0t: result_y expected %h actual %h", $time, exp_res.result_y,
                   m_axis_tdata[63:32]);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                   m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_contacts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    sent_cnt   = 0;
    recv_cnt   = 0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    total_reqs = 1 << 30;

    // Directed: field extremes, each status, both target kinds
    pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    pending_reqs.push_back(mk_req(0, 0, 0, 32'h1_0000, 0, 32'h5_0000, 0, 32'h1_0000, 0));
    pending_reqs.push_back(mk_req(1, 0, 0, 32'h1_8000, 32'h0_C000, 32'h5_0000, 0,
                                  32'h1_0000, 0));
    pending_reqs.push_back(mk_req(0, 0, 0, 32'h1_0000, 0, 32'h5_0000, 32'h10_0000,
                                  32'h1_0000, 0));
    pending_reqs.push_back(mk_req(1, 0, 0, 32'h1_0000, 32'h1_0000, 0, 32'h20_0000, 0,
                                  32'h1_0000));
    pending_reqs.push_back(mk_req(0, 32'h7FFF_0000, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                                  0, 1, 0));
    pending_reqs.push_back(mk_req(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000));
    pending_reqs.push_back(mk_req(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk_req(0, 32'h1234_5678, 32'h8765_4321, 0, 32'h7FFF_FFFF,
                                  32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(mk_req(1, 0, 0, 32'h0_FFFF, 32'h0_0001, 32'h3_0000, 0,
                                  32'hFFFF_0000, 0));
    pending_reqs.push_back(mk_req(1, 0, 0, 32'h0_8000, 32'h0_7FFF, 32'h1_0000, 0,
                                  32'h1_0000, 0));
    pending_reqs.push_back(mk_req(0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 32'h1_0000));
    pending_reqs.push_back(mk_req(0, 32'h100, 32'h200, 32'h2_0000, 0, 32'h100, 32'h200,
                                  32'h7FFF_FFFF, 32'h8000_0000));
    pending_reqs.push_back(mk_req(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
                                  32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                  32'h5555_5555, 32'hAAAA_AAAA));
    pending_reqs.push_back(mk_req(0, 0, 0, 32'h4000_0000, 0, 32'h7FFF_FFFF, 0, 1, 1));
    for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(rand_req());
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests taken, every result back, then a latency margin
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_contacts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d requests: %0d ok, %0d no contact, %0d zero velocity, %0d saturated",
             sent_cnt, status_seen[ST_OK], status_seen[ST_NO_CONTACT],
             status_seen[ST_ZERO_VEL], status_seen[ST_SAT]);
    $display("random stalls on both sides plus one %0d-cycle output hold-off", LONG_HOLD);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/ccb_pkg.sv
src/ccb_mul.sv
src/ccb_sqrt.sv
src/ccb_div.sv
src/ccb_front.sv
src/ccb_fifo.sv
src/ccb_back.sv
src/circle_contact_backoff_unit.sv
bench/tb_circle_contact_backoff_unit.sv
